// ===== sv/tpsa_pkg.sv =====
// ============================================================================
// tpsa_pkg
// Shared types and constants for the two-pool slot allocator.
// ============================================================================
package tpsa_pkg;

    // Most slots a pool holds, and the depth of each free stack
    localparam int unsigned MAX_SLOTS = 1024;

    // Field and register widths
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 11;
    localparam int unsigned FREE_W    = 16;
    localparam int unsigned SLOT_W    = 10;
    localparam int unsigned STATUS_W  = 3;
    // Width that holds any index, capacity or slot count for compares
    localparam int unsigned XW        = 17;

    // Opcodes and pool select
    localparam logic OP_ALLOC     = 1'b0;
    localparam logic OP_FREE      = 1'b1;
    localparam logic POOL_TEXTURE = 1'b0;
    localparam logic POOL_BUFFER  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_ALLOCATED    = 3'd0;
    localparam logic [STATUS_W-1:0] STS_EXHAUSTED    = 3'd1;
    localparam logic [STATUS_W-1:0] STS_DISABLED     = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FREED        = 3'd3;
    localparam logic [STATUS_W-1:0] STS_OUT_OF_RANGE = 3'd4;
    localparam logic [STATUS_W-1:0] STS_STACK_FULL   = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_SLOTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SLOTS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_ENABLED  = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] TEXTURE_SLOTS_RST = 11'd1024;
    localparam logic [CFG_W-1:0] BUFFER_SLOTS_RST  = 11'd1024;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_POP
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // request taken this cycle
        logic load_pop;  // move popped stack entry into the result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pop;       // current request pops a free stack
    } t_sts;

endpackage

// ===== sv/tpsa_datapath.sv =====
// ============================================================================
// tpsa_datapath
// Configuration registers, per-pool counters, free stack memory and the
// result register of the slot allocator.
// ============================================================================
module tpsa_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tpsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpsa_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_opcode,
    input  logic                            i_pool_select,
    input  logic [tpsa_pkg::FREE_W-1:0]     i_free_slot,
    input  tpsa_pkg::t_cmd                  i_cmd,
    output tpsa_pkg::t_sts                  o_sts,
    output logic [tpsa_pkg::SLOT_W-1:0]     o_slot_given,
    output logic [tpsa_pkg::STATUS_W-1:0]   o_status
);

    localparam int unsigned IW    = (tpsa_pkg::MAX_SLOTS > 1) ?
                                    $clog2(tpsa_pkg::MAX_SLOTS) : 1;
    localparam int unsigned CW    = $clog2(tpsa_pkg::MAX_SLOTS + 1);
    localparam int unsigned AW    = IW + 1;
    localparam int unsigned DEPTH = 2 * tpsa_pkg::MAX_SLOTS;
    localparam logic [tpsa_pkg::XW-1:0] MAX_X = tpsa_pkg::XW'(tpsa_pkg::MAX_SLOTS);
    localparam logic [CW-1:0]           MAX_C = CW'(tpsa_pkg::MAX_SLOTS);

    // Configuration registers
    logic [tpsa_pkg::CFG_W-1:0] r_tex_slots;
    logic [tpsa_pkg::CFG_W-1:0] r_buf_slots;
    logic                       r_heap_enabled;

    // Per-pool stack counts and bump pointers
    logic [CW-1:0] r_cnt_tex, r_cnt_buf;
    logic [CW-1:0] r_fresh_tex, r_fresh_buf;

    // Free stacks of both pools, pool select is the top address bit
    logic [IW-1:0] r_mem [DEPTH];
    logic [IW-1:0] r_rdata;

    // Result register
    logic [tpsa_pkg::SLOT_W-1:0]   r_slot;
    logic [tpsa_pkg::STATUS_W-1:0] r_status;

    // Request decode
    logic [tpsa_pkg::CFG_W-1:0]    cap_reg;
    logic [tpsa_pkg::XW-1:0]       cap_x;
    logic [tpsa_pkg::XW-1:0]       eff_x;
    logic [CW-1:0]                 cap;
    logic [CW-1:0]                 cnt;
    logic [CW-1:0]                 fresh;
    logic [CW-1:0]                 cnt_dec;
    logic [CW-1:0]                 cnt_inc;
    logic [CW-1:0]                 n_cnt;
    logic [CW-1:0]                 n_fresh;
    logic [tpsa_pkg::XW-1:0]       free_x;
    logic [tpsa_pkg::XW-1:0]       fresh_x;
    logic [tpsa_pkg::XW-1:0]       rdata_x;
    logic                          pop;
    logic                          push;
    logic                          bump;
    logic [tpsa_pkg::STATUS_W-1:0] status;
    logic [tpsa_pkg::SLOT_W-1:0]   direct_slot;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_addr;

    always_comb begin
        cap_reg = (i_pool_select == tpsa_pkg::POOL_BUFFER) ? r_buf_slots : r_tex_slots;
        cnt     = (i_pool_select == tpsa_pkg::POOL_BUFFER) ? r_cnt_buf : r_cnt_tex;
        fresh   = (i_pool_select == tpsa_pkg::POOL_BUFFER) ? r_fresh_buf : r_fresh_tex;
        // saturate capacity at the stack depth
        cap_x   = tpsa_pkg::XW'(cap_reg);
        eff_x   = (cap_x > MAX_X) ? MAX_X : cap_x;
        cap     = eff_x[CW-1:0];
        free_x  = tpsa_pkg::XW'(i_free_slot);
        fresh_x = tpsa_pkg::XW'(fresh);
        rdata_x = tpsa_pkg::XW'(r_rdata);
        cnt_dec = cnt - CW'(1);
        cnt_inc = cnt + CW'(1);

        pop    = 1'b0;
        push   = 1'b0;
        bump   = 1'b0;
        status = tpsa_pkg::STS_EXHAUSTED;
        if (i_opcode == tpsa_pkg::OP_ALLOC) begin
            if (!r_heap_enabled) begin
                status = tpsa_pkg::STS_DISABLED;
            end else if (cnt != '0) begin
                pop    = 1'b1;
                status = tpsa_pkg::STS_ALLOCATED;
            end else if (fresh >= cap) begin
                status = tpsa_pkg::STS_EXHAUSTED;
            end else begin
                bump   = 1'b1;
                status = tpsa_pkg::STS_ALLOCATED;
            end
        end else begin
            if (free_x >= eff_x) begin
                status = tpsa_pkg::STS_OUT_OF_RANGE;
            end else if (cnt == MAX_C) begin
                status = tpsa_pkg::STS_STACK_FULL;
            end else begin
                push   = 1'b1;
                status = tpsa_pkg::STS_FREED;
            end
        end

        n_cnt   = pop ? cnt_dec : (push ? cnt_inc : cnt);
        n_fresh = bump ? (fresh + CW'(1)) : fresh;
        direct_slot = bump ? fresh_x[tpsa_pkg::SLOT_W-1:0] : '0;
        wr_addr = {i_pool_select, cnt[IW-1:0]};
        rd_addr = {i_pool_select, cnt_dec[IW-1:0]};
    end

    assign o_sts.pop = pop;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_slots    <= tpsa_pkg::TEXTURE_SLOTS_RST;
            r_buf_slots    <= tpsa_pkg::BUFFER_SLOTS_RST;
            r_heap_enabled <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tpsa_pkg::CFG_TEXTURE_SLOTS: r_tex_slots    <= i_cfg_data;
                tpsa_pkg::CFG_BUFFER_SLOTS:  r_buf_slots    <= i_cfg_data;
                tpsa_pkg::CFG_HEAP_ENABLED:  r_heap_enabled <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Advance the selected pool's count and bump pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_tex   <= '0;
            r_cnt_buf   <= '0;
            r_fresh_tex <= '0;
            r_fresh_buf <= '0;
        end else if (i_cmd.accept) begin
            if (i_pool_select == tpsa_pkg::POOL_BUFFER) begin
                r_cnt_buf   <= n_cnt;
                r_fresh_buf <= n_fresh;
            end else begin
                r_cnt_tex   <= n_cnt;
                r_fresh_tex <= n_fresh;
            end
        end
    end

    // Push on free, registered read on pop
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && push) begin
            r_mem[wr_addr] <= free_x[IW-1:0];
        end
        if (i_cmd.accept && pop) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_status <= status;
            r_slot   <= direct_slot;
        end else if (i_cmd.load_pop) begin
            r_slot   <= rdata_x[tpsa_pkg::SLOT_W-1:0];
        end
    end

    assign o_slot_given = r_slot;
    assign o_status     = r_status;

endmodule

// ===== sv/tpsa_ctrl.sv =====
// ============================================================================
// tpsa_ctrl
// Handshake controller: takes requests, waits out the stack read on a pop
// and holds the result beat until the receiver takes it.
// ============================================================================
module tpsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  tpsa_pkg::t_sts i_sts,
    output tpsa_pkg::t_cmd o_cmd
);

    tpsa_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             in_ready;
    logic             accept;

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpsa_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        in_ready     = 1'b0;
        accept       = 1'b0;
        n_state      = r_state;
        o_cmd        = '0;
        n_out_valid  = r_out_valid && !i_out_ready;
        case (r_state)
            tpsa_pkg::ST_IDLE: begin
                in_ready = !r_out_valid || i_out_ready;
                accept   = i_in_valid && in_ready;
                o_cmd.accept = accept;
                if (accept) begin
                    if (i_sts.pop) begin
                        n_state = tpsa_pkg::ST_POP;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            tpsa_pkg::ST_POP: begin
                o_cmd.load_pop = 1'b1;
                n_out_valid    = 1'b1;
                n_state        = tpsa_pkg::ST_IDLE;
            end
            default: begin
                n_state = tpsa_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    // A pop is only entered with an empty result register
    a_pop_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tpsa_pkg::ST_POP |-> !r_out_valid)
        else $error("result still pending during stack read");

    // An accepted pop request moves to the read wait
    a_pop_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_sts.pop |=> r_state == tpsa_pkg::ST_POP)
        else $error("pop request did not wait for stack read");

    // The read wait always ends with a result beat
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tpsa_pkg::ST_POP |=> r_out_valid && r_state == tpsa_pkg::ST_IDLE)
        else $error("stack read produced no result beat");

    // No request is taken while a stalled result would be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken over a stalled result");
`endif

endmodule

// ===== sv/two_pool_slot_allocator.sv =====
// ============================================================================
// two_pool_slot_allocator
// Slot allocator with a LIFO free stack and a bump pointer per pool.
// ============================================================================
// Usage:
//   Request channel (i_in_valid / o_in_ready) carries opcode, pool select and
//   the slot to free. Each request gives exactly one result beat on the
//   result channel (o_out_valid / i_out_ready) with the slot and a status.
//   Configuration writes (i_cfg_valid / o_cfg_ready, index and data) set the
//   two pool capacities and the heap enable; ready is always high, and
//   writes are to be issued only while no request is in flight.
// Result timing:
//   The result beat appears in the cycle after the request is taken; when
//   an allocation pops a free stack, the controller first passes through
//   ST_POP, as the stack memory has a registered read port. A new request
//   is taken every cycle while no result stalls, except during ST_POP.
// Reset:
//   Synchronous, active low. Clears stack counts and bump pointers, sets
//   both capacities to 1024 and enables the heap. Stack contents need no
//   clearing; an entry is read only after it has been pushed.
// Stall:
//   While a result beat waits for i_out_ready, the next request is held off.
// ============================================================================
module two_pool_slot_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tpsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpsa_pkg::CFG_W-1:0]      i_cfg_data,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_opcode,
    input  logic                            i_pool_select,
    input  logic [tpsa_pkg::FREE_W-1:0]     i_free_slot,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tpsa_pkg::SLOT_W-1:0]     o_slot_given,
    output logic [tpsa_pkg::STATUS_W-1:0]   o_status
);

    tpsa_pkg::t_cmd cmd;
    tpsa_pkg::t_sts sts;

    // Configuration writes are never stalled
    assign o_cfg_ready = 1'b1;

    tpsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tpsa_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_pool_select (i_pool_select),
        .i_free_slot   (i_free_slot),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_slot_given  (o_slot_given),
        .o_status      (o_status)
    );

endmodule
